// ===== sv/mwd_pkg.sv =====
// shared types, codes and constants of the memory window decoder
package mwd_pkg;

  localparam int unsigned WINDOW_COUNT_DEF = 8;
  localparam logic [7:0]  VERSION_RESET    = 8'd1;
  localparam logic [7:0]  BYTE_IDLE        = 8'hFF;

  // request types
  localparam logic [1:0] REQ_IO_RD  = 2'd0;
  localparam logic [1:0] REQ_IO_WR  = 2'd1;
  localparam logic [1:0] REQ_MEM_RD = 2'd2;
  localparam logic [1:0] REQ_MEM_WR = 2'd3;

  // io ports, address[2:0]
  localparam logic [2:0] PORT_VERSION = 3'd0;
  localparam logic [2:0] PORT_CMD     = 3'd1;
  localparam logic [2:0] PORT_DATA    = 3'd2;

  // command codes
  localparam logic [7:0] CMD_ENABLE   = 8'd0;
  localparam logic [7:0] CMD_WIN_ID   = 8'd1;
  localparam logic [7:0] CMD_BASE     = 8'd2;
  localparam logic [7:0] CMD_LENGTH   = 8'd3;
  localparam logic [7:0] CMD_KIND     = 8'd4;
  localparam logic [7:0] CMD_FLAGS    = 8'd5;
  localparam logic [7:0] CMD_CTRL     = 8'd6;
  localparam logic [7:0] CMD_CTRL_CMD = 8'd7;

  // handler kinds and flag bits
  localparam logic [7:0] KIND_FIRST   = 8'd1;
  localparam logic [7:0] KIND_LAST    = 8'd5;
  localparam logic [2:0] KIND_NONE    = 3'd0;
  localparam logic [1:0] NEED_RD      = 2'b01;
  localparam logic [1:0] NEED_WR      = 2'b10;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] address;
    logic [7:0]  wdata;
  } in_item_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       mem_hit;
    logic [2:0] hit_window;
  } out_item_t;

  typedef struct packed {
    logic [31:0] base;
    logic [31:0] length;
    logic [2:0]  kind;
    logic [7:0]  flags;
  } win_t;

  // one bit per window field: write enables or valid marks
  typedef struct packed {
    logic base;
    logic length;
    logic kind;
    logic flags;
  } win_fld_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_IO,
    ST_SCAN,
    ST_DONE
  } state_e;

  function automatic int unsigned idx_w(int unsigned n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

// ===== sv/mwd_win_store.sv =====
// window table memory with one write port, one registered read port and valid marks
module mwd_win_store #(
  parameter int unsigned WindowCount = mwd_pkg::WINDOW_COUNT_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  mwd_pkg::win_fld_t                     we_i,
  input  logic [mwd_pkg::idx_w(WindowCount)-1:0] waddr_i,
  input  mwd_pkg::win_t                         wdata_i,
  input  logic [mwd_pkg::idx_w(WindowCount)-1:0] raddr_i,
  output mwd_pkg::win_t                         rdata_o
);
  import mwd_pkg::*;

  logic [31:0] base_mem   [WindowCount];
  logic [31:0] length_mem [WindowCount];
  logic [2:0]  kind_mem   [WindowCount];
  logic [7:0]  flags_mem  [WindowCount];

  logic [WindowCount-1:0] base_vld_q, length_vld_q, kind_vld_q, flags_vld_q;
  win_t     rd_q;
  win_fld_t rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i.base) begin
      base_mem[waddr_i] <= wdata_i.base;
    end
    if (we_i.length) begin
      length_mem[waddr_i] <= wdata_i.length;
    end
    if (we_i.kind) begin
      kind_mem[waddr_i] <= wdata_i.kind;
    end
    if (we_i.flags) begin
      flags_mem[waddr_i] <= wdata_i.flags;
    end
    rd_q.base   <= base_mem[raddr_i];
    rd_q.length <= length_mem[raddr_i];
    rd_q.kind   <= kind_mem[raddr_i];
    rd_q.flags  <= flags_mem[raddr_i];
  end

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_vld_q   <= '0;
      length_vld_q <= '0;
      kind_vld_q   <= '0;
      flags_vld_q  <= '0;
      rd_vld_q     <= '0;
    end else begin
      if (we_i.base) begin
        base_vld_q[waddr_i] <= 1'b1;
      end
      if (we_i.length) begin
        length_vld_q[waddr_i] <= 1'b1;
      end
      if (we_i.kind) begin
        kind_vld_q[waddr_i] <= 1'b1;
      end
      if (we_i.flags) begin
        flags_vld_q[waddr_i] <= 1'b1;
      end
      rd_vld_q.base   <= base_vld_q[raddr_i];
      rd_vld_q.length <= length_vld_q[raddr_i];
      rd_vld_q.kind   <= kind_vld_q[raddr_i];
      rd_vld_q.flags  <= flags_vld_q[raddr_i];
    end
  end

  assign rdata_o.base   = rd_vld_q.base   ? rd_q.base   : '0;
  assign rdata_o.length = rd_vld_q.length ? rd_q.length : '0;
  assign rdata_o.kind   = rd_vld_q.kind   ? rd_q.kind   : KIND_NONE;
  assign rdata_o.flags  = rd_vld_q.flags  ? rd_q.flags  : '0;

endmodule

// ===== sv/mwd_win_cmp.sv =====
// window match unit shared by every step of the memory scan
module mwd_win_cmp (
  input  logic [31:0]   addr_i,
  input  mwd_pkg::win_t win_i,
  input  logic [1:0]    need_i,
  output logic          claim_o
);
  import mwd_pkg::*;

  logic [31:0] win_end;
  logic        covered;

  // end wraps modulo 2^32, so a never written length gives base-1
  assign win_end = win_i.base + win_i.length - 32'd1;
  assign covered = (addr_i >= win_i.base) && (addr_i <= win_end);
  assign claim_o = covered && (win_i.kind != KIND_NONE) && ((win_i.flags[1:0] & need_i) != 2'b00);

endmodule

// ===== sv/memory_window_decoder_regs.sv =====
// top level: io register file, window scan sequencer and result register
//
// Input channel in_valid_i / in_stall_o carries one request (io read, io
// write, memory read or memory write); it is taken when valid is high and
// stall is low. Output channel out_valid_o / out_stall_i returns exactly one
// result per request, in order. The version byte is written over the
// cfg_valid_i / cfg_ready_o channel, which is always ready.
// An io request passes through ST_IO, which uses the window entry read at
// the selected window, and ST_DONE, which hands the result over.
// A memory request scans the window table one entry a clock through the
// single read port of the table memory and the shared match unit; it ends
// at the first window that claims the address or after the last window.
// One request is in work at a time; in_stall_o is high while it is, so the
// next request is taken at best in the cycle the previous result shows.
// When the receiver stalls, the finished result waits in the output register
// and the block holds the next result until it frees. Reset clears the
// control registers but not the request and result data; the window table
// reads as zero and the version byte returns to 1. No clearing pass is needed.
module memory_window_decoder_regs #(
  parameter int unsigned WindowCount = mwd_pkg::WINDOW_COUNT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mwd_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mwd_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_data_i
);
  import mwd_pkg::*;

  localparam int unsigned IdxW = idx_w(WindowCount);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(WindowCount - 1);
  localparam logic [7:0] LastIdxByte = 8'(WindowCount - 1);

  state_e      state_q, state_d;
  in_item_t    req_q, req_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic        chk_q, chk_d;
  logic [IdxW-1:0] chk_idx_q, chk_idx_d;
  out_item_t   res_q, res_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_data_q, out_data_d;

  logic [7:0]      version_q;
  logic [7:0]      cmd_q, cmd_d;
  logic [IdxW-1:0] win_sel_q, win_sel_d;
  logic [31:0]     long_q, long_d;
  logic            genable_q, genable_d;
  logic [7:0]      hcmd_q, hcmd_d;

  win_fld_t    win_we;
  win_t        win_wdata;
  win_t        win_rd;
  logic [IdxW-1:0] raddr;
  logic [1:0]  need;
  logic        claim;
  logic [2:0]  port;
  logic [4:0]  byte_sh;

  mwd_win_store #(
    .WindowCount(WindowCount)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (win_we),
    .waddr_i(win_sel_q),
    .wdata_i(win_wdata),
    .raddr_i(raddr),
    .rdata_o(win_rd)
  );

  mwd_win_cmp u_cmp (
    .addr_i (req_q.address),
    .win_i  (win_rd),
    .need_i (need),
    .claim_o(claim)
  );

  // outside a scan the read port follows the selected window, so its entry
  // is ready in the cycle after an io request is taken
  assign raddr   = (state_q == ST_SCAN) ? cnt_q : win_sel_q;
  assign need    = (req_q.req_type == REQ_MEM_RD) ? NEED_RD : NEED_WR;
  assign port    = req_q.address[2:0];
  assign byte_sh = {req_q.address[1:0], 3'b000};

  assign win_wdata.base   = long_q;
  assign win_wdata.length = (long_q == 32'd0) ? 32'd1 : long_q;
  assign win_wdata.kind   = ((req_q.wdata >= KIND_FIRST) && (req_q.wdata <= KIND_LAST)) ?
                            req_q.wdata[2:0] : KIND_NONE;
  assign win_wdata.flags  = req_q.wdata;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    cnt_d       = cnt_q;
    chk_d       = (state_q == ST_SCAN);
    chk_idx_d   = cnt_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    cmd_d       = cmd_q;
    win_sel_d   = win_sel_q;
    long_d      = long_q;
    genable_d   = genable_q;
    hcmd_d      = hcmd_q;
    win_we      = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          cnt_d   = '0;
          state_d = in_data_i.req_type[1] ? ST_SCAN : ST_IO;
        end
      end
      ST_IO: begin
        res_d.rdata      = BYTE_IDLE;
        res_d.mem_hit    = 1'b0;
        res_d.hit_window = 3'd0;
        if (req_q.req_type == REQ_IO_RD) begin
          if (port == PORT_VERSION) begin
            res_d.rdata = version_q;
          end else if (port == PORT_CMD) begin
            unique case (cmd_q)
              CMD_ENABLE:   res_d.rdata = {7'd0, genable_q};
              CMD_WIN_ID:   res_d.rdata = 8'(win_sel_q);
              CMD_BASE:     long_d = win_rd.base;
              CMD_LENGTH:   long_d = win_rd.length;
              CMD_KIND:     res_d.rdata = {5'd0, win_rd.kind};
              CMD_FLAGS:    res_d.rdata = win_rd.flags;
              CMD_CTRL_CMD: res_d.rdata = hcmd_q;
              default:      res_d.rdata = BYTE_IDLE;
            endcase
          end else if (port[2]) begin
            res_d.rdata = long_q[byte_sh +: 8];
          end
        end else begin
          if (port == PORT_CMD) begin
            cmd_d = req_q.wdata;
          end else if (port == PORT_DATA) begin
            unique case (cmd_q)
              CMD_ENABLE:   genable_d = (req_q.wdata != 8'd0);
              CMD_WIN_ID:   win_sel_d = (req_q.wdata > LastIdxByte) ? LastIdx :
                                        IdxW'(req_q.wdata);
              CMD_BASE:     win_we.base = 1'b1;
              CMD_LENGTH:   win_we.length = 1'b1;
              CMD_KIND:     win_we.kind = 1'b1;
              CMD_FLAGS:    win_we.flags = 1'b1;
              CMD_CTRL_CMD: hcmd_d = req_q.wdata;
              default:      hcmd_d = hcmd_q;
            endcase
          end else if (port[2]) begin
            long_d[byte_sh +: 8] = req_q.wdata;
          end
        end
        state_d = ST_DONE;
      end
      ST_SCAN: begin
        if (cnt_q != LastIdx) begin
          cnt_d = IdxW'(cnt_q + 1'b1);
        end
        // match unit sees the entry read in the previous cycle
        if (chk_q) begin
          res_d.rdata      = BYTE_IDLE;
          res_d.mem_hit    = 1'b0;
          res_d.hit_window = 3'd0;
          if (claim) begin
            res_d.mem_hit    = 1'b1;
            res_d.hit_window = 3'(chk_idx_q);
            state_d          = ST_DONE;
          end else if (chk_idx_q == LastIdx) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      chk_q       <= 1'b0;
      chk_idx_q   <= '0;
      out_valid_q <= 1'b0;
      version_q   <= VERSION_RESET;
      cmd_q       <= '0;
      win_sel_q   <= '0;
      long_q      <= '0;
      genable_q   <= 1'b0;
      hcmd_q      <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      chk_q       <= chk_d;
      chk_idx_q   <= chk_idx_d;
      out_valid_q <= out_valid_d;
      cmd_q       <= cmd_d;
      win_sel_q   <= win_sel_d;
      long_q      <= long_d;
      genable_q   <= genable_d;
      hcmd_q      <= hcmd_d;
      if (cfg_valid_i && cfg_ready_o) begin
        version_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  a_sel_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_sel_q <= LastIdx)
    else $error("selected window out of range");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (cnt_q <= LastIdx) && (chk_idx_q <= LastIdx))
    else $error("scan index out of range");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ST_DONE))
    else $error("result shown without finishing a transaction");

  a_hit_no_rdata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.mem_hit) |-> (out_data_o.rdata == BYTE_IDLE))
    else $error("memory hit carries io read data");

  a_miss_no_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.mem_hit) |-> (out_data_o.hit_window == 3'd0))
    else $error("window index without a hit");

endmodule

// ===== sim/tb_memory_window_decoder_regs.sv =====
// testbench of the memory window decoder: directed and random io and memory requests
`timescale 1ns / 1ps

module tb_memory_window_decoder_regs;
  import mwd_pkg::*;

  class decoder_scoreboard;
    localparam int unsigned WIN_N = WINDOW_COUNT_DEF;

    logic [31:0] win_base   [WIN_N];
    logic [31:0] win_length [WIN_N];
    logic [2:0]  win_kind   [WIN_N];
    logic [7:0]  win_flags  [WIN_N];
    logic        enabled;
    logic [7:0]  sel_cmd;
    logic [2:0]  sel_win;
    logic [31:0] long_value;
    logic [7:0]  ctrl_cmd;
    logic [7:0]  version;
    out_item_t   expected_replies [$];
    int unsigned failures;

    function new();
      for (int i = 0; i < WIN_N; i++) begin
        win_base[i]   = '0;
        win_length[i] = '0;
        win_kind[i]   = KIND_NONE;
        win_flags[i]  = '0;
      end
      enabled    = 1'b0;
      sel_cmd    = CMD_ENABLE;
      sel_win    = '0;
      long_value = '0;
      ctrl_cmd   = '0;
      version    = VERSION_RESET;
      failures   = 0;
    endfunction

    function void run_command(logic [7:0] d);
      unique case (sel_cmd)
        CMD_ENABLE:   enabled = (d != 8'd0);
        CMD_WIN_ID:   sel_win = (d > WIN_N - 1) ? 3'(WIN_N - 1) : d[2:0];
        CMD_BASE:     win_base[sel_win] = long_value;
        CMD_LENGTH:   win_length[sel_win] = (long_value == 32'd0) ? 32'd1 : long_value;
        CMD_KIND:     win_kind[sel_win] = (d >= KIND_FIRST && d <= KIND_LAST) ? d[2:0] : KIND_NONE;
        CMD_FLAGS:    win_flags[sel_win] = d;
        CMD_CTRL_CMD: ctrl_cmd = d;
        default: ;
      endcase
    endfunction

    // a base or length peek loads the long value and drives nothing
    function logic [7:0] read_cmd_port();
      logic [7:0] b;
      b = BYTE_IDLE;
      unique case (sel_cmd)
        CMD_ENABLE:   b = {7'd0, enabled};
        CMD_WIN_ID:   b = {5'd0, sel_win};
        CMD_BASE:     long_value = win_base[sel_win];
        CMD_LENGTH:   long_value = win_length[sel_win];
        CMD_KIND:     b = {5'd0, win_kind[sel_win]};
        CMD_FLAGS:    b = win_flags[sel_win];
        CMD_CTRL_CMD: b = ctrl_cmd;
        default: ;
      endcase
      return b;
    endfunction

    function out_item_t decode_request(in_item_t req);
      out_item_t   r;
      logic [2:0]  port;
      logic [1:0]  need;
      logic [31:0] last;
      r = '{rdata: BYTE_IDLE, mem_hit: 1'b0, hit_window: 3'd0};
      port = req.address[2:0];
      unique case (req.req_type)
        REQ_IO_RD: begin
          if (port == PORT_VERSION) r.rdata = version;
          else if (port == PORT_CMD) r.rdata = read_cmd_port();
          // ports 4 to 7 hold the long value bytes
          else if (port[2]) r.rdata = long_value[{port[1:0], 3'b000} +: 8];
        end
        REQ_IO_WR: begin
          if (port == PORT_CMD) sel_cmd = req.wdata;
          else if (port == PORT_DATA) run_command(req.wdata);
          else if (port[2]) long_value[{port[1:0], 3'b000} +: 8] = req.wdata;
        end
        default: begin
          need = (req.req_type == REQ_MEM_RD) ? NEED_RD : NEED_WR;
          // scan from the top so the lowest claiming window wins
          for (int i = WIN_N - 1; i >= 0; i--) begin
            last = win_base[i] + win_length[i] - 32'd1;
            if (req.address >= win_base[i] && req.address <= last &&
                win_kind[i] != KIND_NONE && (win_flags[i][1:0] & need) != 2'b00) begin
              r.mem_hit    = 1'b1;
              r.hit_window = 3'(i);
            end
          end
        end
      endcase
      return r;
    endfunction

    function void note_request(in_item_t req);
      expected_replies.push_back(decode_request(req));
    endfunction

    function void check_reply(out_item_t got);
      out_item_t want;
      if (expected_replies.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: rdata %h hit %b window %0d",
                   got.rdata, got.mem_hit, got.hit_window);
        return;
      end
      want = expected_replies.pop_front();
      if (got.rdata !== want.rdata || got.mem_hit !== want.mem_hit ||
          got.hit_window !== want.hit_window) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: rdata %h/%h hit %b/%b window %0d/%0d (expected/actual)",
                   want.rdata, got.rdata, want.mem_hit, got.mem_hit,
                   want.hit_window, got.hit_window);
      end
    endfunction
  endclass

  localparam logic [2:0] PORT_SPARE   = 3'd3;
  localparam logic [2:0] PORT_LONG_B0 = 3'd4;
  localparam int unsigned WIN_N       = WINDOW_COUNT_DEF;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = 8'h00;

  decoder_scoreboard sb = new();

  int unsigned sent_items = 0;
  int unsigned tx_calm = 0;
  int unsigned rx_run = 0;
  int unsigned rx_roll;
  logic        rx_level = 1'b0;

  always #5 clk = ~clk;

  memory_window_decoder_regs dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  // result side: check each transaction, then pick the next stall level
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_reply(out_data);
    if (rx_run == 0) begin
      rx_roll = $urandom_range(0, 99);
      if (rx_roll < 50) begin
        rx_level = 1'b0;
        rx_run = $urandom_range(1, 4);
      end else if (rx_roll < 85) begin
        rx_level = 1'b1;
        rx_run = $urandom_range(1, 3);
      end else if (rx_roll < 95) begin
        rx_level = 1'b1;
        rx_run = $urandom_range(8, 30);
      end else begin
        rx_level = 1'b0;
        rx_run = $urandom_range(60, 200);
      end
    end
    rx_run = rx_run - 1;
    out_stall <= rx_level;
  end

  task automatic send_req(logic [1:0] req, logic [31:0] addr, logic [7:0] data);
    int unsigned gap;
    int unsigned roll;
    in_item_t    item;
    item = '{req_type: req, address: addr, wdata: data};
    gap = 0;
    if (tx_calm > 0) begin
      tx_calm--;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll >= 55 && roll < 88) gap = $urandom_range(1, 3);
      else if (roll >= 88 && roll < 97) gap = $urandom_range(8, 30);
      else if (roll >= 97) tx_calm = $urandom_range(40, 150);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    sb.note_request(item);
    sent_items++;
  endtask

  function automatic logic [31:0] io_addr(logic [2:0] port);
    logic [31:0] a;
    a = $urandom();
    a[2:0] = port;
    return a;
  endfunction

  task automatic io_write(logic [2:0] port, logic [7:0] data);
    send_req(REQ_IO_WR, io_addr(port), data);
  endtask

  task automatic io_read(logic [2:0] port);
    send_req(REQ_IO_RD, io_addr(port), 8'($urandom()));
  endtask

  task automatic load_long(logic [31:0] v);
    for (int k = 0; k < 4; k++) io_write(PORT_LONG_B0 + 3'(k), v[8 * k +: 8]);
  endtask

  task automatic program_window(logic [7:0] w, logic [31:0] lo, logic [31:0] len,
                                logic [7:0] kind, logic [7:0] flags);
    io_write(PORT_CMD, CMD_WIN_ID);
    io_write(PORT_DATA, w);
    load_long(lo);
    io_write(PORT_CMD, CMD_BASE);
    io_write(PORT_DATA, 8'($urandom()));
    load_long(len);
    io_write(PORT_CMD, CMD_LENGTH);
    io_write(PORT_DATA, 8'($urandom()));
    io_write(PORT_CMD, CMD_KIND);
    io_write(PORT_DATA, kind);
    io_write(PORT_CMD, CMD_FLAGS);
    io_write(PORT_DATA, flags);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_replies.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_version(logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.version = v;
    io_read(PORT_VERSION);
  endtask

  task automatic run_random(int unsigned count);
    int unsigned stop_at;
    int unsigned roll;
    int unsigned n;
    int unsigned i;
    logic [7:0]  w;
    logic [7:0]  cmd;
    logic [31:0] lo;
    logic [31:0] len;
    logic [31:0] a;
    stop_at = sent_items + count;
    while (sent_items < stop_at) begin
      roll = $urandom_range(0, 99);
      if (roll < 25) begin
        w = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(8, 255))
                                        : 8'($urandom_range(0, WIN_N - 1));
        // clustered bases make overlapping windows common
        lo = ($urandom_range(0, 7) == 0) ? $urandom()
             : 32'h4000_0000 * $urandom_range(0, 3) + $urandom_range(0, 8192);
        case ($urandom_range(0, 7))
          0:       len = 32'd0;
          1:       len = $urandom();
          2:       len = 32'hFFFF_FFFF;
          default: len = $urandom_range(1, 4096);
        endcase
        program_window(w, lo, len,
                       ($urandom_range(0, 5) == 0) ? 8'($urandom())
                                                   : 8'($urandom_range(KIND_FIRST, KIND_LAST)),
                       8'($urandom()));
      end else if (roll < 65) begin
        n = $urandom_range(3, 10);
        repeat (n) begin
          i = $urandom_range(0, WIN_N - 1);
          case ($urandom_range(0, 5))
            0: a = sb.win_base[i];
            1: a = sb.win_base[i] - 32'd1;
            2: a = sb.win_base[i] + sb.win_length[i] - 32'd1;
            3: a = sb.win_base[i] + sb.win_length[i];
            4: a = sb.win_base[i] + $urandom_range(0, 4095);
            default: a = $urandom();
          endcase
          send_req($urandom_range(0, 1) ? REQ_MEM_RD : REQ_MEM_WR, a, 8'($urandom()));
        end
      end else if (roll < 80) begin
        cmd = ($urandom_range(0, 9) == 0) ? 8'($urandom())
                                          : 8'($urandom_range(CMD_ENABLE, CMD_CTRL_CMD));
        io_write(PORT_CMD, cmd);
        io_read(PORT_CMD);
        repeat ($urandom_range(1, 4)) io_read(PORT_LONG_B0 + 3'($urandom_range(0, 3)));
      end else if (roll < 88) begin
        cmd = ($urandom_range(0, 9) == 0) ? 8'($urandom())
                                          : 8'($urandom_range(CMD_ENABLE, CMD_CTRL_CMD));
        io_write(PORT_CMD, cmd);
        io_write(PORT_DATA, $urandom_range(0, 1) ? 8'($urandom()) : 8'h00);
      end else begin
        repeat ($urandom_range(1, 4))
          send_req(2'($urandom_range(0, 3)), $urandom(), 8'($urandom()));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    io_read(PORT_VERSION);
    settle();
    set_version(8'h00);

    // directed: idle ports, never-written length, clamped id, odd kinds and commands
    io_read(PORT_CMD);
    io_read(PORT_SPARE);
    io_read(PORT_DATA);
    io_write(PORT_VERSION, 8'hFF);
    send_req(REQ_MEM_RD, 32'h0000_0000, 8'h00);
    io_write(PORT_CMD, CMD_KIND);
    io_write(PORT_DATA, KIND_FIRST);
    io_write(PORT_CMD, CMD_FLAGS);
    io_write(PORT_DATA, 8'(NEED_RD));
    send_req(REQ_MEM_RD, 32'hFFFF_FFFF, 8'hFF);
    send_req(REQ_MEM_WR, 32'h0000_0000, 8'h00);
    io_write(PORT_CMD, CMD_WIN_ID);
    io_write(PORT_DATA, 8'hFF);
    io_read(PORT_CMD);
    io_write(PORT_CMD, CMD_LENGTH);
    io_write(PORT_DATA, 8'h00);
    io_write(PORT_CMD, CMD_KIND);
    io_write(PORT_DATA, KIND_LAST + 8'd1);
    io_read(PORT_CMD);
    io_write(PORT_CMD, 8'hC3);
    io_read(PORT_CMD);
    io_write(PORT_LONG_B0 + 3'd3, 8'hA5);
    io_read(PORT_LONG_B0 + 3'd3);
    io_write(PORT_CMD, CMD_CTRL);
    io_read(PORT_CMD);
    settle();

    set_version(8'hFF);
    run_random(330);
    settle();
    set_version(8'($urandom()));
    run_random(330);
    settle();
    set_version(VERSION_RESET);
    run_random(330);
    settle();
    set_version(8'h80);
    run_random(330);
    settle();

    if (sb.failures == 0 && sb.expected_replies.size() == 0) begin
      $display("tb_memory_window_decoder_regs OK");
    end else begin
      $display("tb_memory_window_decoder_regs NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_memory_window_decoder_regs NOT OK");
    $finish;
  end
endmodule
